// ===== design/tilted_lidar_point_to_xyz_core_defines.svh =====
// Assertion macros used by the point conversion top level.
`ifndef TILTED_LIDAR_POINT_TO_XYZ_CORE_DEFINES_SVH
`define TILTED_LIDAR_POINT_TO_XYZ_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TLX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlx check failed");

// Next-cycle implication, checked out of reset.
`define TLX_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlx check failed");

`endif

// ===== design/tlx_pkg.sv =====
// Types and constants for the tilted lidar point conversion.
package tlx_pkg;

  localparam int CORDIC_STEPS = 20;
  localparam int XY_W = 33;
  localparam int Z_W  = 25;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ANGLE_MIN     = 2'd0;
  localparam logic [1:0] CFG_ANGLE_STEP    = 2'd1;
  localparam logic [1:0] CFG_SENSOR_OFFSET = 2'd2;

  // One rotation lane: coordinates in Q30, residual angle in 1/2^24 turn.
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } tlx_rot_t;

  // Item fields that ride along the rotation chain.
  typedef struct packed {
    logic [15:0] range_dist;
    logic [15:0] echo;
    logic [1:0]  q_t;
    logic [1:0]  q_p;
  } tlx_side_t;

  // What one cell hands to the next.
  typedef struct packed {
    logic      valid;
    tlx_rot_t  th;
    tlx_rot_t  ph;
    tlx_side_t side;
  } tlx_bus_t;

  // Arctangent of 2^-i in 1/2^24 turn.
  function automatic logic signed [Z_W-1:0] atan_turn(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:       v = 25'sd2097152;
      1:       v = 25'sd1238021;
      2:       v = 25'sd654136;
      3:       v = 25'sd332050;
      4:       v = 25'sd166669;
      5:       v = 25'sd83416;
      6:       v = 25'sd41718;
      7:       v = 25'sd20860;
      8:       v = 25'sd10430;
      9:       v = 25'sd5215;
      10:      v = 25'sd2608;
      11:      v = 25'sd1304;
      12:      v = 25'sd652;
      13:      v = 25'sd326;
      14:      v = 25'sd163;
      15:      v = 25'sd81;
      16:      v = 25'sd41;
      17:      v = 25'sd20;
      18:      v = 25'sd10;
      19:      v = 25'sd5;
      default: v = 25'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/tlx_cell.sv =====
// One CORDIC rotation cell, rotating the beam and tilt lanes by one step.
module tlx_cell #(
  parameter int STEP = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tlx_pkg::tlx_bus_t up,
  output logic             up_ready,
  output tlx_pkg::tlx_bus_t dn,
  input  logic             dn_ready
);

  localparam logic signed [tlx_pkg::Z_W-1:0] ATAN = tlx_pkg::atan_turn(STEP);

  logic               valid_r;
  tlx_pkg::tlx_rot_t  th_r, th_nxt;
  tlx_pkg::tlx_rot_t  ph_r, ph_nxt;
  tlx_pkg::tlx_side_t side_r;

  // One micro-rotation toward a zero residual angle.
  function automatic tlx_pkg::tlx_rot_t rotate(input tlx_pkg::tlx_rot_t a);
    tlx_pkg::tlx_rot_t     o;
    logic signed [tlx_pkg::XY_W-1:0] dx;
    logic signed [tlx_pkg::XY_W-1:0] dy;
    dx = a.y >>> STEP;
    dy = a.x >>> STEP;
    if (!a.z[tlx_pkg::Z_W-1]) begin
      o.x = a.x - dx;
      o.y = a.y + dy;
      o.z = a.z - ATAN;
    end else begin
      o.x = a.x + dx;
      o.y = a.y - dy;
      o.z = a.z + ATAN;
    end
    return o;
  endfunction

  assign th_nxt   = rotate(up.th);
  assign ph_nxt   = rotate(up.ph);
  assign up_ready = !valid_r || dn_ready;

  // Valid bit of this cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up.valid;
    end
  end

  // Rotation payload.
  always_ff @(posedge clk) begin
    if (up_ready && up.valid) begin
      th_r   <= th_nxt;
      ph_r   <= ph_nxt;
      side_r <= up.side;
    end
  end

  assign dn.valid = valid_r;
  assign dn.th    = th_r;
  assign dn.ph    = ph_r;
  assign dn.side  = side_r;

endmodule

// ===== design/tilted_lidar_point_to_xyz_core.sv =====
// Top level of the tilted lidar point to x/y/z converter.
//
// Input channel (in_*): one lidar return per transfer: range, intensity,
// beam column and tilt motor position. Output channel (out_*): one point
// per input, x/y/z in 1/1024 m and the intensity copied through.
// Configuration (cfg_*): write angle_min, angle_step or sensor_offset
// with cfg_we, cfg_addr and cfg_wdata while no item is in flight.
// Throughput: one item per cycle unless the receiver stalls. Items pass
// from input transfer to output valid through 28 registers: three angle
// stages, one quadrant stage, a chain of 20 CORDIC cells and four
// product stages, the last of which is the output register.
// Every stage has its own valid bit and takes new data when it is empty
// or its successor moves, so bubbles close up and the input stays ready
// while a finished point waits at the output. When the receiver stalls,
// the output holds and the pipeline fills, then in_ready drops.
// Reset (synchronous, active low) empties the pipeline and loads the
// configuration registers with their default values.
`include "tilted_lidar_point_to_xyz_core_defines.svh"
module tilted_lidar_point_to_xyz_core #(
  parameter int POINTS_PER_LINE = 1024,
  parameter int TILT_COUNTS     = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [15:0]         in_range_dist,
  input  logic [15:0]         in_echo_strength,
  input  logic [9:0]          in_beam_column,
  input  logic [11:0]         in_tilt_position,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [17:0]  out_pos_x,
  output logic signed [17:0]  out_pos_y,
  output logic signed [17:0]  out_pos_z,
  output logic [15:0]         out_echo_out,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [23:0]         cfg_wdata
);

  // Tilt divide: tilt*2^24/T = tilt*TQ + (tilt*TR)/T, the last by reciprocal.
  localparam longint TQ_L = (64'd1 << 24) / TILT_COUNTS;
  localparam longint TR_L = (64'd1 << 24) % TILT_COUNTS;
  localparam longint TM_L = (64'd1 << 32) / TILT_COUNTS;
  localparam logic [16:0] TQ = 17'(TQ_L);
  localparam logic [16:0] TR = 17'(TR_L);
  localparam logic [24:0] TM = 25'(TM_L);
  localparam logic [16:0] TC = 17'(TILT_COUNTS);

  // Configuration registers.
  logic [23:0]        angle_min_r;
  logic [23:0]        angle_step_r;
  logic signed [15:0] sensor_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_min_r     <= 24'hA00000;
      angle_step_r    <= 24'd12300;
      sensor_offset_r <= 16'sd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        tlx_pkg::CFG_ANGLE_MIN:     angle_min_r     <= cfg_wdata;
        tlx_pkg::CFG_ANGLE_STEP:    angle_step_r    <= cfg_wdata;
        tlx_pkg::CFG_SENSOR_OFFSET: sensor_offset_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Stage ready chain.
  logic rdy_s0, rdy_s1, rdy_s2, rdy_s3, rdy_p1, rdy_p2, rdy_p3, rdy_out;
  logic v_s0_r, v_s1_r, v_s2_r, v_p1_r, v_p2_r, v_p3_r, out_valid_r;
  tlx_pkg::tlx_bus_t bus [0:tlx_pkg::CORDIC_STEPS];
  logic              rdy_c [0:tlx_pkg::CORDIC_STEPS];
  tlx_pkg::tlx_bus_t s3_r, s3_nxt;

  assign rdy_out  = !out_valid_r || out_ready;
  assign rdy_p3   = !v_p3_r || rdy_out;
  assign rdy_p2   = !v_p2_r || rdy_p3;
  assign rdy_p1   = !v_p1_r || rdy_p2;
  assign rdy_c[tlx_pkg::CORDIC_STEPS] = rdy_p1;
  assign rdy_s3   = !s3_r.valid || rdy_c[0];
  assign rdy_s2   = !v_s2_r || rdy_s3;
  assign rdy_s1   = !v_s1_r || rdy_s2;
  assign rdy_s0   = !v_s0_r || rdy_s1;
  assign in_ready = rdy_s0;

  // Valid bits of the stages outside the cell chain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s0_r      <= 1'b0;
      v_s1_r      <= 1'b0;
      v_s2_r      <= 1'b0;
      v_p1_r      <= 1'b0;
      v_p2_r      <= 1'b0;
      v_p3_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy_s0)  v_s0_r      <= in_valid;
      if (rdy_s1)  v_s1_r      <= v_s0_r;
      if (rdy_s2)  v_s2_r      <= v_s1_r;
      if (rdy_p1)  v_p1_r      <= bus[tlx_pkg::CORDIC_STEPS].valid;
      if (rdy_p2)  v_p2_r      <= v_p1_r;
      if (rdy_p3)  v_p3_r      <= v_p2_r;
      if (rdy_out) out_valid_r <= v_p3_r;
    end
  end

  // Stage 0: beam angle and tilt remainder product.
  logic [9:0]  col_sat;
  logic [33:0] col_prod;
  logic [23:0] s0_theta_r;
  logic [28:0] s0_n_r;
  logic [11:0] s0_tilt_r;
  logic [15:0] s0_r_r, s0_echo_r;

  assign col_sat  = ({22'd0, in_beam_column} >= 32'(POINTS_PER_LINE)) ?
                    10'(POINTS_PER_LINE - 1) : in_beam_column;
  assign col_prod = col_sat * angle_step_r;

  always_ff @(posedge clk) begin
    if (rdy_s0 && in_valid) begin
      s0_theta_r <= col_prod[23:0] + angle_min_r;
      s0_n_r     <= in_tilt_position * TR;
      s0_tilt_r  <= in_tilt_position;
      s0_r_r     <= in_range_dist;
      s0_echo_r  <= in_echo_strength;
    end
  end

  // Stage 1: quotient estimate by reciprocal, whole-turn part.
  logic [53:0] est_prod;
  logic [28:0] tq_prod;
  logic [23:0] s1_theta_r;
  logic [28:0] s1_n_r;
  logic [11:0] s1_est_r;
  logic [23:0] s1_tq_r;
  logic [15:0] s1_r_r, s1_echo_r;

  assign est_prod = s0_n_r * TM;
  assign tq_prod  = s0_tilt_r * TQ;

  always_ff @(posedge clk) begin
    if (rdy_s1 && v_s0_r) begin
      s1_theta_r <= s0_theta_r;
      s1_n_r     <= s0_n_r;
      s1_est_r   <= est_prod[43:32];
      s1_tq_r    <= tq_prod[23:0];
      s1_r_r     <= s0_r_r;
      s1_echo_r  <= s0_echo_r;
    end
  end

  // Stage 2: quotient correction and half-turn shift of the tilt angle.
  logic [28:0] est_back;
  logic [28:0] rem;
  logic        corr;
  logic [23:0] s2_theta_r, s2_phi_r;
  logic [15:0] s2_r_r, s2_echo_r;

  assign est_back = s1_est_r * TC;
  assign rem      = s1_n_r - est_back;
  assign corr     = (rem >= {12'd0, TC});

  always_ff @(posedge clk) begin
    if (rdy_s2 && v_s1_r) begin
      s2_theta_r <= s1_theta_r;
      s2_phi_r   <= s1_tq_r + {12'd0, s1_est_r} + {23'd0, corr} + 24'h800000;
      s2_r_r     <= s1_r_r;
      s2_echo_r  <= s1_echo_r;
    end
  end

  // Stage 3: quadrant reduction and CORDIC start vector.
  function automatic logic [1:0] quad_of(input logic [23:0] a);
    logic [23:0] s;
    s = a + 24'h200000;
    return s[23:22];
  endfunction

  function automatic tlx_pkg::tlx_rot_t start_of(input logic [23:0] a);
    tlx_pkg::tlx_rot_t o;
    logic [23:0]       s;
    s   = a + 24'h200000;
    o.x = tlx_pkg::CORDIC_GAIN;
    o.y = '0;
    o.z = $signed({3'b000, s[21:0]}) - 25'sd2097152;
    return o;
  endfunction

  assign s3_nxt.valid           = v_s2_r;
  assign s3_nxt.th              = start_of(s2_theta_r);
  assign s3_nxt.ph              = start_of(s2_phi_r);
  assign s3_nxt.side.range_dist = s2_r_r;
  assign s3_nxt.side.echo       = s2_echo_r;
  assign s3_nxt.side.q_t        = quad_of(s2_theta_r);
  assign s3_nxt.side.q_p        = quad_of(s2_phi_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.valid <= 1'b0;
    end else if (rdy_s3) begin
      s3_r.valid <= s3_nxt.valid;
    end
    if (rdy_s3 && v_s2_r) begin
      s3_r.th   <= s3_nxt.th;
      s3_r.ph   <= s3_nxt.ph;
      s3_r.side <= s3_nxt.side;
    end
  end

  // CORDIC cell chain.
  assign bus[0] = s3_r;

  for (genvar i = 0; i < tlx_pkg::CORDIC_STEPS; i++) begin : g_cell
    tlx_cell #(.STEP(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up       (bus[i]),
      .up_ready (rdy_c[i]),
      .dn       (bus[i+1]),
      .dn_ready (rdy_c[i+1])
    );
  end

  // P1: quadrant unfold and rounding to Q20.
  function automatic logic signed [21:0] rnd10(input logic signed [32:0] v);
    logic signed [33:0] s;
    s = 34'(v) + 34'sd512;
    return 22'(s >>> 10);
  endfunction

  function automatic logic signed [43:0] unfold(input tlx_pkg::tlx_rot_t a,
                                                input logic [1:0] q);
    logic signed [32:0] c, s;
    case (q)
      2'd0:    begin c = a.x;  s = a.y;  end
      2'd1:    begin c = -a.y; s = a.x;  end
      2'd2:    begin c = -a.x; s = -a.y; end
      default: begin c = a.y;  s = -a.x; end
    endcase
    return {rnd10(c), rnd10(s)};
  endfunction

  tlx_pkg::tlx_bus_t  last;
  logic signed [43:0] cs_t, cs_p;
  logic signed [21:0] p1_ct_r, p1_st_r, p1_cp_r, p1_sp_r;
  logic [15:0]        p1_r_r, p1_echo_r;

  assign last = bus[tlx_pkg::CORDIC_STEPS];
  assign cs_t = unfold(last.th, last.side.q_t);
  assign cs_p = unfold(last.ph, last.side.q_p);

  always_ff @(posedge clk) begin
    if (rdy_p1 && last.valid) begin
      p1_ct_r   <= cs_t[43:22];
      p1_st_r   <= cs_t[21:0];
      p1_cp_r   <= cs_p[43:22];
      p1_sp_r   <= cs_p[21:0];
      p1_r_r    <= last.side.range_dist;
      p1_echo_r <= last.side.echo;
    end
  end

  // P2: range and offset products.
  logic signed [16:0] r_s;
  logic signed [38:0] p2_t_r, p2_ys_r;
  logic signed [37:0] p2_hs_r, p2_hc_r;
  logic signed [21:0] p2_cp_r, p2_sp_r;
  logic [15:0]        p2_echo_r;

  assign r_s = $signed({1'b0, p1_r_r});

  always_ff @(posedge clk) begin
    if (rdy_p2 && v_p1_r) begin
      p2_t_r    <= r_s * p1_ct_r;
      p2_ys_r   <= r_s * p1_st_r;
      p2_hs_r   <= sensor_offset_r * p1_sp_r;
      p2_hc_r   <= sensor_offset_r * p1_cp_r;
      p2_cp_r   <= p1_cp_r;
      p2_sp_r   <= p1_sp_r;
      p2_echo_r <= p1_echo_r;
    end
  end

  // P3: split products of t with the tilt terms, y rounding.
  logic signed [18:0] t_hi;
  logic signed [20:0] t_lo;
  logic signed [39:0] ys_rnd;
  logic signed [40:0] p3_hc_c_r, p3_hs_s_r;
  logic signed [42:0] p3_lc_r, p3_ls_r;
  logic signed [37:0] p3_hs_r, p3_hc_r;
  logic signed [17:0] p3_y_r;
  logic [15:0]        p3_echo_r;

  assign t_hi   = p2_t_r[38:20];
  assign t_lo   = $signed({1'b0, p2_t_r[19:0]});
  assign ys_rnd = 40'(p2_ys_r) + 40'sd524288;

  always_ff @(posedge clk) begin
    if (rdy_p3 && v_p2_r) begin
      p3_hc_c_r <= t_hi * p2_cp_r;
      p3_hs_s_r <= t_hi * p2_sp_r;
      p3_lc_r   <= t_lo * p2_cp_r;
      p3_ls_r   <= t_lo * p2_sp_r;
      p3_hs_r   <= p2_hs_r;
      p3_hc_r   <= p2_hc_r;
      p3_y_r    <= ys_rnd[37:20];
      p3_echo_r <= p2_echo_r;
    end
  end

  // Output register: final sums and rounding by 2^40.
  logic signed [63:0] x_full, z_full;
  logic signed [17:0] x_r, y_r, z_r;
  logic [15:0]        echo_r;

  assign x_full = (64'(p3_hc_c_r) <<< 20) + 64'(p3_lc_r) - (64'(p3_hs_r) <<< 20)
                  + (64'sd1 <<< 39);
  assign z_full = (64'(p3_hs_s_r) <<< 20) + 64'(p3_ls_r) + (64'(p3_hc_r) <<< 20)
                  + (64'sd1 <<< 39);

  always_ff @(posedge clk) begin
    if (rdy_out && v_p3_r) begin
      x_r    <= x_full[57:40];
      y_r    <= p3_y_r;
      z_r    <= z_full[57:40];
      echo_r <= p3_echo_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pos_x    = x_r;
  assign out_pos_y    = y_r;
  assign out_pos_z    = z_r;
  assign out_echo_out = echo_r;

  // An empty output register never blocks the input.
  `TLX_ASSERT_IMP(a_ready_when_empty, !out_valid_r, in_ready)
  // An input transfer always lands in the first stage.
  `TLX_ASSERT_NXT(a_in_lands, in_valid && in_ready, v_s0_r)
  // A finished item moves into a free output register.
  `TLX_ASSERT_NXT(a_out_fills, v_p3_r && !out_valid_r, out_valid_r)

endmodule
